FILE: rtl/smv_pkg.sv
// smv_pkg: shared types, constants and the section type lookup for the
// section map validator. No dependencies.
`default_nettype none

package smv_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam logic [33:0] HDR_WORD_BYTES = 34'd4;
  localparam logic [33:0] MAP_ITEM_BYTES = 34'd12;
  localparam logic [15:0] CODE_ITEM_TYPE = 16'h2001;
  localparam logic [4:0]  KIND_UNKNOWN   = 5'd21;

  typedef enum logic [1:0] {
    CFG_MAP_OFFSET  = 2'd0,
    CFG_FILE_BYTES  = 2'd1,
    CFG_ENTRY_COUNT = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    STAT_OK         = 4'd0,
    STAT_NO_MAP     = 4'd1,
    STAT_EMPTY      = 4'd2,
    STAT_TOO_MANY   = 4'd3,
    STAT_PAST_END   = 4'd4,
    STAT_OUT_BOUNDS = 4'd5,
    STAT_UNSORTED   = 4'd6,
    STAT_DUP_TYPE   = 4'd7,
    STAT_SEQUENCE   = 4'd8
  } status_t;

  typedef enum logic [0:0] {
    MODE_START = 1'b0,
    MODE_ENTRY = 1'b1
  } mode_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] entry_type;
    logic [31:0] entry_offset;
  } item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] seg_offset;
    logic [31:0] seg_size;
    logic [4:0]  kind;
    logic        executable;
    logic        start_gap;
    logic        last;
  } result_t;

  // control handed from the sequencer to every cell of the chain
  typedef struct packed {
    logic [15:0]      key_type;
    logic [CNT_W-1:0] count;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [15:0]      wr_type;
    logic [31:0]      wr_off;
    logic             shift;
  } chain_ctl_t;

  function automatic logic [4:0] kind_of(input logic [15:0] t);
    logic [4:0] k;
    unique case (t)
      16'h0000: k = 5'd0;
      16'h0001: k = 5'd1;
      16'h0002: k = 5'd2;
      16'h0003: k = 5'd3;
      16'h0004: k = 5'd4;
      16'h0005: k = 5'd5;
      16'h0006: k = 5'd6;
      16'h0007: k = 5'd7;
      16'h0008: k = 5'd8;
      16'h1000: k = 5'd9;
      16'h1001: k = 5'd10;
      16'h1002: k = 5'd11;
      16'h1003: k = 5'd12;
      16'h2000: k = 5'd13;
      16'h2001: k = 5'd14;
      16'h2002: k = 5'd15;
      16'h2003: k = 5'd16;
      16'h2004: k = 5'd17;
      16'h2005: k = 5'd18;
      16'h2006: k = 5'd19;
      16'hF000: k = 5'd20;
      default:  k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/smv_cell.sv
// smv_cell: one map entry slot: stored type and offset, a registered type
// match against the incoming item, and a shift path toward the head.
// Depends on smv_pkg.
`default_nettype none

module smv_cell (
  input  wire logic                     clk,
  input  wire logic [smv_pkg::IDX_W-1:0] idx,
  input  wire smv_pkg::chain_ctl_t      ctl,
  input  wire logic [15:0]              next_type,
  input  wire logic [31:0]              next_off,
  output logic      [15:0]              ctype,
  output logic      [31:0]              coff,
  output logic                          hit
);

  logic in_run;

  // only slots written in the current run take part in the compare
  assign in_run = {1'b0, idx} < ctl.count;

  always_ff @(posedge clk) begin
    hit <= in_run && (ctype == ctl.key_type);
    if (ctl.wr_en && (ctl.wr_idx == idx)) begin
      ctype <= ctl.wr_type;
      coff  <= ctl.wr_off;
    end else if (ctl.shift) begin
      ctype <= next_type;
      coff  <= next_off;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/smv_chain.sv
// smv_chain: row of smv_cell slots; gives the duplicate hit and the two
// head slots used while segments are emitted. Depends on smv_pkg, smv_cell.
`default_nettype none

module smv_chain (
  input  wire logic                clk,
  input  wire smv_pkg::chain_ctl_t ctl,
  output logic                     hit_any,
  output logic [15:0]              head_type,
  output logic [31:0]              head_off,
  output logic [31:0]              second_off
);

  logic [15:0] types [smv_pkg::MAX_ENTRIES+1];
  logic [31:0] offs  [smv_pkg::MAX_ENTRIES+1];
  logic [smv_pkg::MAX_ENTRIES-1:0] hits;

  // slot past the tail feeds zeros into the shift path
  assign types[smv_pkg::MAX_ENTRIES] = '0;
  assign offs[smv_pkg::MAX_ENTRIES]  = '0;

  for (genvar i = 0; i < smv_pkg::MAX_ENTRIES; i++) begin : g_cell
    smv_cell u_cell (
      .clk       (clk),
      .idx       (smv_pkg::IDX_W'(i)),
      .ctl       (ctl),
      .next_type (types[i+1]),
      .next_off  (offs[i+1]),
      .ctype     (types[i]),
      .coff      (offs[i]),
      .hit       (hits[i])
    );
  end

  assign hit_any    = |hits;
  assign head_type  = types[0];
  assign head_off   = offs[0];
  assign second_off = offs[1];

endmodule

`default_nettype wire

FILE: rtl/section_map_validator.sv
// section_map_validator: checks a section map and emits its segments.
// A start item answers in the cycle after it is taken (error) or silently.
// An entry item of a collecting run holds busy while it is checked, so no new item
// is taken before it is done; the compare of its type against the run's stored entries is
// one registered cell stage. The last entry is followed by one segment a cycle.
// Reset clears configuration and run state; the entry slots are not cleared.
`default_nettype none

module section_map_validator (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire smv_pkg::item_t   item,
  output smv_pkg::result_t      result,
  output logic                  result_valid,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [31:0]      cfg_data
);

  localparam int CW = smv_pkg::CNT_W;

  typedef enum logic [2:0] {
    ST_READY = 3'b001,
    ST_CHECK = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_COLLECT = 4'b0010,
    PH_FAILED  = 4'b0100,
    PH_DONE    = 4'b1000
  } phase_t;

  state_t      state;
  phase_t      phase;
  logic [31:0] map_offset;
  logic [31:0] file_bytes;
  logic [31:0] entry_count;
  logic [CW-1:0] entries_seen;
  logic [CW-1:0] run_count;
  logic [CW-1:0] emit_idx;
  logic [31:0] run_size;
  logic [31:0] prev_off;
  logic [15:0] pend_type;
  logic [31:0] pend_off;

  smv_pkg::chain_ctl_t ctl;
  logic        hit_any;
  logic [15:0] head_type;
  logic [31:0] head_off;
  logic [31:0] second_off;

  logic        accept;
  logic [33:0] table_end;
  logic        fail_bounds;
  logic        fail_order;
  logic        commit;
  logic        emit_last;
  logic [CW-1:0] seen_next;
  smv_pkg::result_t result_next;

  assign busy      = (state != ST_READY);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign table_end = {2'b00, map_offset} + smv_pkg::HDR_WORD_BYTES +
                     34'(entry_count[CW-1:0]) * smv_pkg::MAP_ITEM_BYTES;

  assign fail_bounds = pend_off >= run_size;
  assign fail_order  = (entries_seen != '0) && (pend_off <= prev_off);
  assign commit      = (state == ST_CHECK) && !fail_bounds && !fail_order && !hit_any;
  assign seen_next   = entries_seen + CW'(1);
  assign emit_last   = (emit_idx + CW'(1)) == run_count;

  always_comb begin
    ctl          = '0;
    ctl.key_type = item.entry_type;
    ctl.count    = entries_seen;
    ctl.wr_en    = commit;
    ctl.wr_idx   = entries_seen[smv_pkg::IDX_W-1:0];
    ctl.wr_type  = pend_type;
    ctl.wr_off   = pend_off;
    ctl.shift    = (state == ST_EMIT);
  end

  smv_chain u_chain (
    .clk        (clk),
    .ctl        (ctl),
    .hit_any    (hit_any),
    .head_type  (head_type),
    .head_off   (head_off),
    .second_off (second_off)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      map_offset  <= '0;
      file_bytes  <= '0;
      entry_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        smv_pkg::CFG_MAP_OFFSET:  map_offset  <= cfg_data;
        smv_pkg::CFG_FILE_BYTES:  file_bytes  <= cfg_data;
        smv_pkg::CFG_ENTRY_COUNT: entry_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    result_next      = '0;
    result_next.last = 1'b1;
    if (accept && item.mode == smv_pkg::MODE_START) begin
      priority if (map_offset == '0)   result_next.status = smv_pkg::STAT_NO_MAP;
      else if (entry_count == '0)      result_next.status = smv_pkg::STAT_EMPTY;
      else if (entry_count > 32'(smv_pkg::MAX_ENTRIES))
                                       result_next.status = smv_pkg::STAT_TOO_MANY;
      else                             result_next.status = smv_pkg::STAT_PAST_END;
    end else if (accept) begin
      result_next.status = smv_pkg::STAT_SEQUENCE;
    end else if (state == ST_CHECK) begin
      priority if (fail_bounds) result_next.status = smv_pkg::STAT_OUT_BOUNDS;
      else if (fail_order)      result_next.status = smv_pkg::STAT_UNSORTED;
      else                      result_next.status = smv_pkg::STAT_DUP_TYPE;
    end else begin
      result_next.status     = smv_pkg::STAT_OK;
      result_next.seg_offset = head_off;
      result_next.seg_size   = emit_last ? (run_size - head_off) : (second_off - head_off);
      result_next.kind       = smv_pkg::kind_of(head_type);
      result_next.executable = (head_type == smv_pkg::CODE_ITEM_TYPE);
      result_next.start_gap  = (emit_idx == '0) && (head_off != '0);
      result_next.last       = emit_last;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_type <= item.entry_type;
      pend_off  <= item.entry_offset;
    end
    result <= result_next;
    if (commit) begin
      prev_off <= pend_off;
    end
  end

  // sequencer and run state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_READY;
      phase        <= PH_IDLE;
      entries_seen <= '0;
      run_count    <= '0;
      run_size     <= '0;
      emit_idx     <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        ST_READY: begin
          if (accept && item.mode == smv_pkg::MODE_START) begin
            entries_seen <= '0;
            if (map_offset == '0 || entry_count == '0 ||
                entry_count > 32'(smv_pkg::MAX_ENTRIES) ||
                table_end > {2'b00, file_bytes}) begin
              phase        <= PH_FAILED;
              result_valid <= 1'b1;
            end else begin
              phase     <= PH_COLLECT;
              run_size  <= file_bytes;
              run_count <= entry_count[CW-1:0];
            end
          end else if (accept) begin
            if (phase == PH_COLLECT && entries_seen < run_count) begin
              state <= ST_CHECK;
            end else if (phase != PH_FAILED) begin
              result_valid <= 1'b1;
            end
          end
        end
        ST_CHECK: begin
          if (commit) begin
            entries_seen <= seen_next;
            if (seen_next == run_count) begin
              state    <= ST_EMIT;
              phase    <= PH_DONE;
              emit_idx <= '0;
            end else begin
              state <= ST_READY;
            end
          end else begin
            phase        <= PH_FAILED;
            state        <= ST_READY;
            result_valid <= 1'b1;
          end
        end
        ST_EMIT: begin
          result_valid <= 1'b1;
          emit_idx     <= emit_idx + CW'(1);
          if (emit_last) begin
            state <= ST_READY;
          end
        end
        default: state <= ST_READY;
      endcase
    end
  end

  a_check_in_run: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHECK |-> phase == PH_COLLECT && entries_seen < run_count)
    else $error("entry check outside a collecting run");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> emit_idx < run_count && entries_seen == run_count)
    else $error("segment index past entry count");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != smv_pkg::STAT_OK |-> result.last)
    else $error("error item not marked last");

  a_mid_segment: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> state == ST_EMIT)
    else $error("non-final item outside emission");

  a_collect_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_COLLECT |-> entries_seen < run_count && run_count != '0)
    else $error("collecting run with full or empty table");

endmodule

`default_nettype wire

FILE: bench/section_map_validator_test.sv
`timescale 1ns / 1ps
// section_map_validator_test: self-checking bench for section_map_validator.
// Keeps a behavioral model of the map checker and compares every result; uses smv_pkg.

module section_map_validator_test;

  localparam int SETTLE       = 8;
  localparam int CYCLE_LIMIT  = 250000;
  localparam int RANDOM_ITEMS = 110;

  typedef enum logic [1:0] {
    RUN_IDLE,
    RUN_COLLECT,
    RUN_FAILED,
    RUN_DONE
  } run_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  smv_pkg::item_t   item = '0;
  smv_pkg::result_t result;
  logic             result_valid;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  logic [31:0]      cfg_data = '0;

  section_map_validator uut (
    .clk, .rst, .start, .busy, .item, .result, .result_valid,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // spec type list in kind order
  logic [15:0] spec_codes [0:20] = '{
    16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005, 16'h0006,
    16'h0007, 16'h0008, 16'h1000, 16'h1001, 16'h1002, 16'h1003, 16'h2000,
    16'h2001, 16'h2002, 16'h2003, 16'h2004, 16'h2005, 16'h2006, 16'hF000
  };

  // model state
  logic [31:0] reg_map_offset = '0;
  logic [31:0] reg_file_bytes = '0;
  logic [31:0] reg_entry_count = '0;
  logic [31:0] run_size = '0;
  logic [31:0] run_count = '0;
  run_t        map_phase = RUN_IDLE;
  int          entries_seen = 0;
  logic [15:0] slot_type [smv_pkg::MAX_ENTRIES];
  logic [31:0] slot_offset [smv_pkg::MAX_ENTRIES];

  smv_pkg::result_t map_results_due [$];

  int  items_taken = 0;
  int  segments_seen = 0;
  int  errors_seen = 0;
  int  mismatches = 0;
  int  cycles = 0;
  bit  steady_run = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [4:0] spec_kind(logic [15:0] t);
    for (int i = 0; i < 21; i++)
      if (spec_codes[i] == t) return 5'(i);
    return smv_pkg::KIND_UNKNOWN;
  endfunction

  function automatic void flag_status(smv_pkg::status_t s);
    smv_pkg::result_t r;
    r = '0;
    r.status = s;
    r.last = 1'b1;
    map_results_due.push_back(r);
  endfunction

  // returns 1 when the item is dropped without effect
  function automatic bit check_map_item(smv_pkg::item_t it);
    logic [63:0]      table_end;
    logic [31:0]      stop;
    smv_pkg::result_t r;
    int               n;
    if (it.mode == smv_pkg::MODE_START) begin
      entries_seen = 0;
      map_phase = RUN_FAILED;
      if (reg_map_offset == 0) flag_status(smv_pkg::STAT_NO_MAP);
      else if (reg_entry_count == 0) flag_status(smv_pkg::STAT_EMPTY);
      else if (reg_entry_count > smv_pkg::MAX_ENTRIES) flag_status(smv_pkg::STAT_TOO_MANY);
      else begin
        table_end = {32'd0, reg_map_offset} + smv_pkg::HDR_WORD_BYTES +
                    {32'd0, reg_entry_count} * smv_pkg::MAP_ITEM_BYTES;
        if (table_end > {32'd0, reg_file_bytes}) flag_status(smv_pkg::STAT_PAST_END);
        else begin
          run_size = reg_file_bytes;
          run_count = reg_entry_count;
          map_phase = RUN_COLLECT;
        end
      end
      return 1'b0;
    end
    if (map_phase == RUN_FAILED) return 1'b1;
    if (map_phase != RUN_COLLECT || entries_seen >= run_count) begin
      flag_status(smv_pkg::STAT_SEQUENCE);
      return 1'b0;
    end
    n = entries_seen;
    if (it.entry_offset >= run_size) begin
      map_phase = RUN_FAILED;
      flag_status(smv_pkg::STAT_OUT_BOUNDS);
      return 1'b0;
    end
    if (n > 0 && it.entry_offset <= slot_offset[n-1]) begin
      map_phase = RUN_FAILED;
      flag_status(smv_pkg::STAT_UNSORTED);
      return 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      if (slot_type[i] == it.entry_type) begin
        map_phase = RUN_FAILED;
        flag_status(smv_pkg::STAT_DUP_TYPE);
        return 1'b0;
      end
    end
    slot_type[n] = it.entry_type;
    slot_offset[n] = it.entry_offset;
    entries_seen = n + 1;
    if (entries_seen < run_count) return 1'b0;
    // table complete: one segment per entry, in order
    map_phase = RUN_DONE;
    for (int i = 0; i < entries_seen; i++) begin
      stop = (i + 1 < entries_seen) ? slot_offset[i+1] : run_size;
      r = '0;
      r.status = smv_pkg::STAT_OK;
      r.seg_offset = slot_offset[i];
      r.seg_size = stop - slot_offset[i];
      r.kind = spec_kind(slot_type[i]);
      r.executable = (slot_type[i] == smv_pkg::CODE_ITEM_TYPE);
      r.start_gap = (i == 0 && slot_offset[i] != 0);
      r.last = (i + 1 == entries_seen);
      map_results_due.push_back(r);
    end
    return 1'b0;
  endfunction

  // result checker: the block cannot stall its output
  always @(posedge clk) begin : check_results
    smv_pkg::result_t want;
    if (!rst && result_valid) begin
      if (result.status == smv_pkg::STAT_OK) segments_seen++;
      else errors_seen++;
      if (map_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %h at cycle %0d", result, cycles);
      end else begin
        want = map_results_due.pop_front();
        if (result.status !== want.status || result.seg_offset !== want.seg_offset ||
            result.seg_size !== want.seg_size || result.kind !== want.kind ||
            result.executable !== want.executable ||
            result.start_gap !== want.start_gap || result.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at cycle %0d: status %0d/%0d off %h/%h size %h/%h",
                      " kind %0d/%0d exe %b/%b gap %b/%b last %b/%b"},
                     cycles, want.status, result.status, want.seg_offset,
                     result.seg_offset, want.seg_size, result.seg_size,
                     want.kind, result.kind, want.executable, result.executable,
                     want.start_gap, result.start_gap, want.last, result.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               map_results_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int idle_gap();
    int r;
    if (steady_run) return 0;
    r = $urandom_range(0, 19);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic smv_pkg::item_t map_item(smv_pkg::mode_t m, logic [15:0] t,
                                              logic [31:0] o);
    smv_pkg::item_t it;
    it.mode = m;
    it.entry_type = t;
    it.entry_offset = o;
    return it;
  endfunction

  // start stays high after acceptance; the next send or a drain decides what follows
  task automatic send_item(input smv_pkg::item_t it);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (!check_map_item(it)) items_taken++;
  endtask

  task automatic send_start();
    send_item(map_item(smv_pkg::MODE_START, 16'($urandom_range(0, 16'hFFFF)), $urandom));
  endtask

  task automatic send_entry(input logic [15:0] t, input logic [31:0] o);
    send_item(map_item(smv_pkg::MODE_ENTRY, t, o));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (map_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input smv_pkg::cfg_idx_t idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      smv_pkg::CFG_MAP_OFFSET:  reg_map_offset = value;
      smv_pkg::CFG_FILE_BYTES:  reg_file_bytes = value;
      smv_pkg::CFG_ENTRY_COUNT: reg_entry_count = value;
      default: ;
    endcase
  endtask

  task automatic load_map_regs(input logic [31:0] map_off, input logic [31:0] file_len,
                               input logic [31:0] count);
    drain();
    write_reg(smv_pkg::CFG_MAP_OFFSET, map_off);
    write_reg(smv_pkg::CFG_FILE_BYTES, file_len);
    write_reg(smv_pkg::CFG_ENTRY_COUNT, count);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_header_checks();
    send_entry(16'h0001, 32'h10);
    send_start();
    drain();
    write_reg(smv_pkg::CFG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
    load_map_regs(32'h70, 32'h1000, 32'd0);
    send_start();
    load_map_regs(32'h70, 32'h1000, 32'd65);
    send_start();
    load_map_regs(32'h70, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_start();
    // table end overflows 32 bits
    load_map_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
    send_start();
    load_map_regs(32'h70, 32'h70 + 4 + 12 * 64 - 1, 32'd64);
    send_start();
    send_entry(16'h0000, 32'h0);
  endtask

  task automatic test_entry_checks();
    load_map_regs(32'h70, 32'h1000, 32'd4);
    send_start();
    send_entry(16'h0000, 32'h1000);
    send_entry(16'h0001, 32'h10);
    send_start();
    send_entry(16'h0000, 32'h0);
    send_entry(16'h0001, 32'h0);
    send_start();
    send_entry(16'h2001, 32'h10);
    send_entry(16'h2001, 32'h20);
    send_start();
    send_entry(16'h0000, 32'h0);
    send_entry(16'h2001, 32'h100);
    send_entry(16'hFFFF, 32'h200);
    send_entry(16'hF000, 32'hFFF);
    send_entry(16'h0002, 32'h800);
  endtask

  task automatic test_extremes();
    load_map_regs(32'h1, 32'hFFFF_FFFF, 32'd2);
    send_start();
    send_entry(16'h1003, 32'h8000_0000);
    send_entry(16'h2001, 32'hFFFF_FFFE);
    // table ends exactly at the file end
    load_map_regs(32'hFFFF_FFEF, 32'hFFFF_FFFF, 32'd1);
    send_start();
    send_entry(16'h2006, 32'h0);
  endtask

  task automatic test_restart();
    load_map_regs(32'h70, 32'h2000, 32'd3);
    send_start();
    send_entry(16'h0003, 32'h40);
    send_entry(16'h0004, 32'h80);
    send_start();
    send_entry(16'h0004, 32'h10);
    send_entry(16'h0003, 32'h20);
    send_entry(16'h2001, 32'h1FFF);
    send_start();
    send_entry(16'h0005, 32'h0);
  endtask

  task automatic random_round(input bit full_table);
    logic [31:0] file_len, map_off, count;
    logic [63:0] cur, room;
    logic [15:0] types [smv_pkg::MAX_ENTRIES];
    logic [31:0] offs [smv_pkg::MAX_ENTRIES];
    logic [15:0] t;
    logic [31:0] o;
    int          shape, fault, at, noise;
    bit          clash;
    steady_run = ($urandom_range(0, 3) == 0);
    shape = full_table ? 0 : $urandom_range(0, 19);
    count = (shape == 0) ? smv_pkg::MAX_ENTRIES : $urandom_range(1, 8);
    case ($urandom_range(0, 3))
      0:       file_len = 32'hFFFF_FFFF;
      1:       file_len = $urandom | 32'h0001_0000;
      default: file_len = 4 + 12 * count + 1 + $urandom_range(0, 4096);
    endcase
    map_off = $urandom_range(1, file_len - 4 - 12 * count);
    case (shape)
      1: map_off = 0;
      2: count = 0;
      3: count = ($urandom_range(0, 1) == 0) ? $urandom_range(65, 200)
                                              : ($urandom | 32'h100);
      4: map_off = file_len - 4 - 12 * count + $urandom_range(1, 64);
      default: ;
    endcase
    load_map_regs(map_off, file_len, count);

    if (shape >= 1 && shape <= 4) begin
      send_start();
      noise = $urandom_range(0, 2);
      repeat (noise) send_entry(16'($urandom_range(0, 16'hFFFF)), $urandom);
      return;
    end

    // well-formed table: rising offsets inside the file, distinct types
    cur = ($urandom_range(0, 3) == 0) ? 64'd0
                                      : {32'd0, $urandom_range(0, (file_len - count) / 2)};
    for (int i = 0; i < count; i++) begin
      offs[i] = cur[31:0];
      if (i < count - 1) begin
        room = ({32'd0, file_len} - 1 - cur) / (count - 1 - i);
        cur = cur + 1 + $urandom_range(0, room[31:0] - 1);
      end
      do begin
        t = ($urandom_range(0, 3) != 0) ? spec_codes[$urandom_range(0, 20)]
                                         : 16'($urandom_range(0, 16'hFFFF));
        clash = 1'b0;
        for (int j = 0; j < i; j++) if (types[j] == t) clash = 1'b1;
      end while (clash);
      types[i] = t;
    end

    fault = full_table ? 0 : $urandom_range(0, 9);
    at = $urandom_range(0, count - 1);
    if (fault == 9) begin
      // abandoned run, then the whole table again
      send_start();
      for (int i = 0; i < at; i++) send_entry(types[i], offs[i]);
    end
    send_start();
    for (int i = 0; i < count; i++) begin
      t = types[i];
      o = offs[i];
      if (i == at) begin
        case (fault)
          6: o = file_len + $urandom_range(0, 32'hFFFF_FFFF - file_len);
          7: if (i > 0) o = $urandom_range(0, offs[i-1]);
          8: if (i > 0) t = types[$urandom_range(0, i - 1)];
          default: ;
        endcase
      end
      send_entry(t, o);
    end
    if (fault >= 6 && fault <= 8) begin
      noise = $urandom_range(0, 2);
      repeat (noise) send_entry(16'($urandom_range(0, 16'hFFFF)), $urandom);
    end else if (fault == 5) begin
      send_entry(16'($urandom_range(0, 16'hFFFF)), $urandom);
    end
  endtask

  task automatic test_random_maps();
    int goal;
    goal = items_taken + RANDOM_ITEMS;
    random_round(1'b1);
    while (items_taken < goal) random_round(1'b0);
    steady_run = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_header_checks();
    test_entry_checks();
    test_extremes();
    test_restart();
    test_random_maps();
    drain();
    $display("checked %0d items against %0d segments and %0d error results",
             items_taken, segments_seen, errors_seen);
    $display("header faults, entry faults, restarts and tables of 1 to %0d entries; %0d mismatches",
             smv_pkg::MAX_ENTRIES, mismatches);
    if (mismatches == 0 && map_results_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: section_map_validator.f
rtl/smv_pkg.sv
rtl/smv_cell.sv
rtl/smv_chain.sv
rtl/section_map_validator.sv
bench/section_map_validator_test.sv
